[sv/aeng_pkg.sv]
// aeng_pkg: shared types and constants for the adaptive EMA noise gate.
// No dependencies; imported by the interfaces and every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package aeng_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int FILT_W     = 32;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_IDX_W  = 2;

  localparam int BASE_W  = 17;
  localparam int MAX_W   = 17;
  localparam int GAIN_W  = 16;
  localparam int FLOOR_W = 15;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HI   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_FLOOR = 2'd3;

  localparam logic [BASE_W-1:0]  ALPHA_LO_RST   = 17'd6554;
  localparam logic [MAX_W-1:0]   ALPHA_HI_RST   = 17'd65536;
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 16'd256;
  localparam logic [FLOOR_W-1:0] GATE_FLOOR_RST = 15'd0;

  typedef struct packed {
    logic [BASE_W-1:0]  alpha_lo;
    logic [MAX_W-1:0]   alpha_hi;
    logic [GAIN_W-1:0]  gain;
    logic [FLOOR_W-1:0] gate_floor;
  } cfg_t;

endpackage

`default_nettype wire

[sv/aeng_if.sv]
// aeng_in_if / aeng_out_if: valid/ready channels carrying one sample item
// and one filtered result item. Depends on aeng_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface aeng_in_if;
  import aeng_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface aeng_out_if;
  import aeng_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [FILT_W-1:0] filtered;
  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

`default_nettype wire

[sv/aeng_cfg.sv]
// aeng_cfg: configuration register file (alpha floor, alpha ceiling, gain,
// gate threshold). Depends on aeng_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aeng_cfg (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [aeng_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire [aeng_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output aeng_pkg::cfg_t                  cfg
);
  import aeng_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha_lo   <= ALPHA_LO_RST;
      cfg_r.alpha_hi   <= ALPHA_HI_RST;
      cfg_r.gain       <= GAIN_RST;
      cfg_r.gate_floor <= GATE_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ALPHA_LO:   cfg_r.alpha_lo   <= cfg_wdata[BASE_W-1:0];
        REG_ALPHA_HI:   cfg_r.alpha_hi   <= cfg_wdata[MAX_W-1:0];
        REG_GAIN:       cfg_r.gain       <= cfg_wdata[GAIN_W-1:0];
        REG_GATE_FLOOR: cfg_r.gate_floor <= cfg_wdata[FLOOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[sv/aeng_mul.sv]
// aeng_mul: shared signed multiplier with a registered product, used once for
// gain*|diff| and once for diff*alpha per item. Depends on aeng_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aeng_mul #(
  parameter int A_W = 34,
  parameter int B_W = 18
) (
  input  wire                         clk,
  input  wire                         en,
  input  wire  signed [A_W-1:0]       a,
  input  wire  signed [B_W-1:0]       b,
  output logic signed [A_W+B_W-1:0]   p
);
  import aeng_pkg::*;

  logic signed [A_W+B_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

[sv/adaptive_ema_noise_gate.sv]
// adaptive_ema_noise_gate: top level with the item sequencer, filter state
// and output register. Depends on aeng_pkg, aeng_if, aeng_cfg, aeng_mul.
`timescale 1ns / 1ps
`default_nettype none

// Adaptive EMA with noise gate. Each accepted sample item updates a Q16.16
// filtered value and produces exactly one result item. An item passes through the
// steps accept, difference, gain multiply, alpha clamp, step multiply, update.
// Both multiplies go through the single shared multiplier; in_ch.ready is high
// only in the idle state. The result sits in an output register, so the next
// item can be accepted while the previous result waits; the update stalls only
// if a result is still unclaimed when the next one is ready. Configuration
// writes take effect on the next item and are to be made while the block is
// idle.
module adaptive_ema_noise_gate #(
  parameter int GAIN_SHIFT      = 8,
  parameter int ALPHA_FRAC_BITS = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire [aeng_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire [aeng_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  aeng_in_if.sink                         in_ch,
  aeng_out_if.source                      out_ch
);
  import aeng_pkg::*;

  localparam int AW    = (ALPHA_FRAC_BITS + 1 > BASE_W) ? ALPHA_FRAC_BITS + 1 : BASE_W;
  localparam int DW    = FILT_W + 1;   // signed difference
  localparam int MA_W  = DW + 1;       // multiplier operand A
  localparam int MB_W  = AW + 1;       // multiplier operand B
  localparam int PW    = MA_W + MB_W;
  localparam int TSH   = GAIN_SHIFT + 16;
  localparam logic [AW-1:0] ONE = AW'(1) << ALPHA_FRAC_BITS;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIFF, ST_GAIN, ST_ALPHA, ST_STEP, ST_UPD
  } state_t;

  cfg_t cfg;

  aeng_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  state_t                    state_r;
  logic                      out_valid_r;
  logic signed [SAMPLE_W-1:0] s_r;
  logic signed [DW-1:0]      d_r;
  logic        [DW-1:0]      diff_r;
  logic        [AW-1:0]      alpha_r;
  logic signed [FILT_W-1:0]  f_r;

  // shared multiplier
  logic                      mul_en;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PW-1:0]      mul_p;

  always_comb begin
    mul_en = (state_r == ST_GAIN) || (state_r == ST_STEP);
    if (state_r == ST_GAIN) begin
      mul_a = signed'({1'b0, diff_r});
      mul_b = signed'(MB_W'(cfg.gain));
    end else begin
      mul_a = MA_W'(d_r);
      mul_b = signed'({1'b0, alpha_r});
    end
  end

  aeng_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // difference stage: noise gate, then S - f and f - S in parallel
  logic [SAMPLE_W-1:0]        s_mag;
  logic [FILT_W-1:0]          f_mag;
  logic                       gate;
  logic signed [SAMPLE_W-1:0] s_g;
  logic signed [DW-1:0]       s_ext;
  logic signed [DW-1:0]       f_ext;
  logic signed [DW-1:0]       d_nxt;
  logic signed [DW-1:0]       nd;
  logic        [DW-1:0]       diff_nxt;

  always_comb begin
    s_mag = s_r[SAMPLE_W-1] ? SAMPLE_W'(-s_r) : SAMPLE_W'(s_r);
    f_mag = f_r[FILT_W-1] ? FILT_W'(-f_r) : FILT_W'(f_r);
    gate  = (s_mag < SAMPLE_W'(cfg.gate_floor)) &&
            (f_mag < FILT_W'({cfg.gate_floor, 16'd0}));
    s_g   = gate ? '0 : s_r;
    s_ext = DW'(signed'({s_g, 16'd0}));
    f_ext = DW'(f_r);
    d_nxt = s_ext - f_ext;
    nd    = f_ext - s_ext;
    diff_nxt = d_nxt[DW-1] ? $unsigned(nd) : $unsigned(d_nxt);
  end

  // alpha stage: base + gain term, clamp to max then up to base
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [PW:0]   a_sum;
  logic [AW-1:0] a_min;
  logic [AW-1:0] alpha_nxt;

  always_comb begin
    lo    = (AW'(cfg.alpha_lo) > ONE) ? ONE : AW'(cfg.alpha_lo);
    hi    = (AW'(cfg.alpha_hi) > ONE) ? ONE : AW'(cfg.alpha_hi);
    a_sum = (PW+1)'(lo) + (PW+1)'($unsigned(mul_p) >> TSH);
    a_min = (a_sum > (PW+1)'(hi)) ? hi : a_sum[AW-1:0];
    alpha_nxt = (a_min < lo) ? lo : a_min;
  end

  // update stage: floor(d*alpha / ONE) via arithmetic shift
  logic signed [PW-1:0]     delta;
  logic signed [FILT_W-1:0] f_nxt;
  logic                     upd_go;

  always_comb begin
    delta  = mul_p >>> ALPHA_FRAC_BITS;
    f_nxt  = f_r + delta[FILT_W-1:0];
    upd_go = (state_r == ST_UPD) && (!out_valid_r || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      f_r         <= '0;
      s_r         <= '0;
      d_r         <= '0;
      diff_r      <= '0;
      alpha_r     <= '0;
    end else begin
      // a result taken in the same cycle as the update is replaced below
      if (out_valid_r && out_ch.ready && !upd_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            s_r     <= in_ch.sample;
            state_r <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          d_r     <= d_nxt;
          diff_r  <= diff_nxt;
          state_r <= ST_GAIN;
        end
        ST_GAIN:  state_r <= ST_ALPHA;
        ST_ALPHA: begin
          alpha_r <= alpha_nxt;
          state_r <= ST_STEP;
        end
        ST_STEP:  state_r <= ST_UPD;
        ST_UPD: begin
          if (upd_go) begin
            f_r         <= f_nxt;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = f_r;

  // an accepted item always moves on to the difference stage
  a_accept_to_diff: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == ST_DIFF))
    else $error("accepted item did not enter difference stage");

  // a new result only appears out of the update stage
  a_result_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPD))
    else $error("result raised outside update stage");

  // filter state only changes on an update
  a_state_on_upd: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(f_r) |-> ($past(state_r == ST_UPD) || $past(!rst_n)))
    else $error("filtered value changed outside update");

  // the clamped smoothing factor never exceeds one
  a_alpha_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_STEP) |-> (alpha_r <= ONE))
    else $error("alpha above one");

  // an update never overwrites a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && out_valid_r && !out_ch.ready) |=> (state_r == ST_UPD))
    else $error("update left while result pending");

endmodule

`default_nettype wire

[sim/adaptive_ema_noise_gate_test.sv]
// Self-checking testbench for adaptive_ema_noise_gate: directed and random sample items
// over several register settings, each result checked against an in-bench filter model.
// Depends on aeng_pkg, aeng_if and the RTL of the block.
`timescale 1ns / 1ps

module adaptive_ema_noise_gate_test;
  import aeng_pkg::*;

  localparam int GAIN_SHIFT = 8;
  localparam int ALPHA_BITS = 16;
  localparam longint ALPHA_ONE = 64'sd1 <<< ALPHA_BITS;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  aeng_in_if  in_if ();
  aeng_out_if out_if ();

  adaptive_ema_noise_gate dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_if),
    .out_ch    (out_if)
  );

  // filter model: register copies and the Q16.16 state
  logic [BASE_W-1:0]        base_m;
  logic [MAX_W-1:0]         max_m;
  logic [GAIN_W-1:0]        gain_m;
  logic [FLOOR_W-1:0]       floor_m;
  logic signed [FILT_W-1:0] filt_m;

  logic signed [FILT_W-1:0] pending_filtered[$];
  logic signed [FILT_W-1:0] want_filtered;
  int  errors = 0;
  bit  calm = 1'b0;
  int  gap_odds = 0;
  int  stall_odds = 0;
  int  hold_left = 0;
  int  odds_choice[4] = '{0, 2, 4, 8};

  always #5 clk = ~clk;

  function automatic logic signed [FILT_W-1:0] next_filtered(
    input logic signed [FILT_W-1:0] f32, input logic signed [SAMPLE_W-1:0] smp);
    longint s, f, d, diff, lo, hi, alpha;
    s = smp;
    f = f32;
    // gate only when both the sample and the held value sit under the floor
    if ((s < 0 ? -s : s) < longint'(floor_m) &&
        (f < 0 ? -f : f) < longint'(floor_m) * 65536)
      s = 0;
    d = s * 65536 - f;
    diff = d < 0 ? -d : d;
    lo = (longint'(base_m) > ALPHA_ONE) ? ALPHA_ONE : longint'(base_m);
    hi = (longint'(max_m) > ALPHA_ONE) ? ALPHA_ONE : longint'(max_m);
    alpha = lo + ((longint'(gain_m) * diff) >>> (GAIN_SHIFT + 16));
    if (alpha > hi) alpha = hi;
    if (alpha < lo) alpha = lo;   // base wins when limits cross
    return FILT_W'(f + ((d * alpha) >>> ALPHA_BITS));
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clip16(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return SAMPLE_W'(v);
  endfunction

  // result side: random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!calm && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      out_if.ready <= 1'b0;
      hold_left <= int'($urandom_range(0, 5));
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_filtered.size() == 0) begin
        $error("filtered: expected nothing, got %0d", out_if.filtered);
        errors++;
      end else begin
        want_filtered = pending_filtered.pop_front();
        if (out_if.filtered !== want_filtered) begin
          $error("filtered: expected %0d, got %0d", want_filtered, out_if.filtered);
          errors++;
        end
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= v;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    filt_m = next_filtered(filt_m, v);
    pending_filtered.push_back(filt_m);
  endtask

  // drop valid, wait for every result, then let the pipeline drain
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_filtered.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_regs(input logic [CFG_DATA_W-1:0] b, m, g, nf);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= REG_ALPHA_LO;
    cfg_wdata <= b;
    @(posedge clk);
    cfg_idx <= REG_ALPHA_HI;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_idx <= REG_GAIN;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_idx <= REG_GATE_FLOOR;
    cfg_wdata <= nf;
    @(posedge clk);
    cfg_we <= 1'b0;
    base_m = b;
    max_m = m;
    gain_m = g[GAIN_W-1:0];
    floor_m = nf[FLOOR_W-1:0];
  endtask

  task automatic test_extremes();
    gap_odds = 4;
    stall_odds = 4;
    send_sample(16'sd32767);
    send_sample(16'sd32767);
    send_sample(-16'sd32768);
    send_sample(-16'sd32768);
    send_sample(16'sd0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
  endtask

  task automatic test_alpha_limits();
    // base above one saturates: output jumps straight to the sample
    set_regs(17'h1FFFF, 17'd0, 17'd0, 17'd0);
    send_sample(16'sd1234);
    // alpha pinned at zero: output holds
    set_regs(17'd0, 17'd0, 17'd65535, 17'd0);
    send_sample(-16'sd30000);
    // crossed limits, gain write with the spare top bit set
    set_regs(17'd40000, 17'd10000, 17'h1FFFF, 17'd0);
    send_sample(-16'sd20000);
    send_sample(16'sd7);
    // max above one saturates, full gain
    set_regs(17'd0, 17'h1FFFF, 17'd65535, 17'd0);
    send_sample(-16'sd32768);
    send_sample(16'sd32767);
  endtask

  task automatic test_noise_gate();
    // alpha fixed at one so each output shows the gated sample directly
    set_regs(17'd65536, 17'd65536, 17'd0, 17'd100);
    send_sample(16'sd99);
    send_sample(-16'sd99);
    send_sample(16'sd100);   // equal to floor: passes
    send_sample(16'sd50);    // held value still at the floor: passes
    send_sample(16'sd20);    // both under: gated
    set_regs(17'd65536, 17'd65536, 17'd0, 17'h1FFFF);
    send_sample(-16'sd32767);
    send_sample(-16'sd32768);
  endtask

  // runs of samples around a level, so the filter settles and the gate can open
  task automatic run_samples(input int n);
    int sent;
    int level;
    int run_len;
    int lim;
    sent = 0;
    while (sent < n) begin
      lim = int'(floor_m) + 8;
      case ($urandom_range(0, 5))
        0, 1: level = int'($signed(16'($urandom)));
        2, 3: level = int'($urandom_range(0, 2 * lim)) - lim;
        4: level = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        default: level = 0;
      endcase
      run_len = $urandom_range(1, 12);
      for (int i = 0; i < run_len && sent < n; i++) begin
        send_sample(clip16(level + int'($urandom_range(0, 6)) - 3));
        sent++;
      end
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return CFG_DATA_W'($urandom_range(65537, 131071));
      3: return CFG_DATA_W'($urandom);
      default: return CFG_DATA_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic test_random_settings(input int phases, input int per_phase);
    logic [CFG_DATA_W-1:0] g;
    logic [CFG_DATA_W-1:0] nf;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 5))
        0: g = 17'd0;
        1: g = 17'h1FFFF;
        2: g = CFG_DATA_W'($urandom);
        3, 4: g = CFG_DATA_W'($urandom_range(0, 1024));
        default: g = CFG_DATA_W'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 5))
        0: nf = 17'd0;
        1: nf = 17'h1FFFF;
        2: nf = CFG_DATA_W'($urandom);
        default: nf = CFG_DATA_W'($urandom_range(1, 3000));
      endcase
      set_regs(pick_alpha(), pick_alpha(), g, nf);
      gap_odds = odds_choice[$urandom_range(0, 3)];
      stall_odds = odds_choice[$urandom_range(0, 3)];
      run_samples(per_phase);
    end
  endtask

  task automatic test_full_rate();
    set_regs(pick_alpha(), pick_alpha(), CFG_DATA_W'($urandom_range(0, 2048)),
             CFG_DATA_W'($urandom_range(0, 500)));
    calm = 1'b1;
    run_samples(120);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_ALPHA_LO;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.sample <= '0;
    base_m = ALPHA_LO_RST;
    max_m = ALPHA_HI_RST;
    gain_m = GAIN_RST;
    floor_m = GATE_FLOOR_RST;
    filt_m = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_alpha_limits();
    test_noise_gate();
    test_random_settings(7, 105);
    test_full_rate();

    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
